FILE: rtl/gdft_pkg.sv
package gdft_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int SLOT_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VALUE_W      = 32;

  typedef enum logic [1:0] {
    REQ_ADD_VERTEX = 2'd0,
    REQ_ADD_ARC    = 2'd1,
    REQ_TRAVERSE   = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_ARC_SCAN,
    S_POP,
    S_SCAN
  } state_t;

endpackage

FILE: rtl/graph_depth_first_traversal_core.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   req_type, vertex_value, arc_to_value
// out      output     out_valid/out_stall status, visited_value, visited_slot, last_of_run
//
// Add vertex and unknown requests go straight to the response; add arc scans the
// vertex table, one table compare per cycle. Traverse with N vertices: a pop per vertex,
// an adjacency scan over all N slots after each pop but the last, and a restart from
// the highest unseen slot whenever the stack runs dry.
// rst (synchronous) empties the vertex table and clears the adjacency matrix.
// out_stall holds the sequencer at every word; a word may wait while the next item is taken.
module graph_depth_first_traversal_core
  import gdft_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] vertex_value,
  input  logic signed [VALUE_W-1:0] arc_to_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] visited_value,
  output logic [SLOT_W-1:0]         visited_slot,
  output logic                      last_of_run
);

  state_t state, state_next;

  logic [CNT_W-1:0]          count;
  logic [VALUE_W-1:0]        values [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   adj    [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   seen;
  logic [SLOT_W-1:0]         stack  [MAX_VERTICES];
  logic [CNT_W-1:0]          depth;
  logic [CNT_W-1:0]          remaining;

  logic [VALUE_W-1:0]        req_a, req_b;
  logic [CNT_W-1:0]          idx;
  logic                      found_f, found_t;
  logic [SLOT_W-1:0]         f_slot, t_slot;
  logic [SLOT_W-1:0]         jdx;
  logic [SLOT_W-1:0]         cur;
  status_t                   resp_status;

  logic                      accept;
  logic                      can_emit;
  logic [SLOT_W-1:0]         pick;
  logic [CNT_W-1:0]          depth_m1;
  logic [SLOT_W-1:0]         top;
  logic                      scan_hit;
  logic                      scan_end;
  logic                      arc_end;
  logic [VALUE_W-1:0]        scan_value;
  logic                      emit_resp, emit_visit, push_pick, push_scan;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_emit = !out_valid || !out_stall;

  // highest slot not yet seen, used when the stack runs dry
  always_comb begin
    pick = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if ((CNT_W'(i) < count) && !seen[i]) pick = SLOT_W'(i);
    end
  end

  assign depth_m1   = depth - CNT_W'(1);
  assign top        = stack[depth_m1[SLOT_W-1:0]];
  assign scan_hit   = adj[cur][jdx] && !seen[jdx];
  assign scan_end   = (CNT_W'(jdx) == (count - CNT_W'(1)));
  assign arc_end    = (idx == count);
  assign scan_value = values[idx[SLOT_W-1:0]];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_ADD_ARC:  state_next = S_ARC_SCAN;
            REQ_TRAVERSE: state_next = (count == '0) ? S_RESP : S_POP;
            default:      state_next = S_RESP;
          endcase
        end
      end
      S_RESP:     if (can_emit) state_next = S_IDLE;
      S_ARC_SCAN: if (arc_end) state_next = S_RESP;
      S_POP: begin
        if ((depth != '0) && can_emit)
          state_next = (remaining == CNT_W'(1)) ? S_IDLE : S_SCAN;
      end
      S_SCAN:     if (scan_end) state_next = S_POP;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit_resp  = (state == S_RESP) && can_emit;
    emit_visit = (state == S_POP) && (depth != '0) && can_emit;
    push_pick  = (state == S_POP) && (depth == '0);
    push_scan  = (state == S_SCAN) && scan_hit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      depth     <= '0;
      remaining <= '0;
      seen      <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) adj[i] <= '0;
    end else begin
      state <= state_next;

      if (emit_resp || emit_visit) out_valid <= 1'b1;
      else if (!out_stall)         out_valid <= 1'b0;

      if (accept && (req_type == REQ_ADD_VERTEX) && (count < CNT_W'(MAX_VERTICES)))
        count <= count + CNT_W'(1);

      if (accept && (req_type == REQ_TRAVERSE) && (count != '0)) begin
        seen      <= MAX_VERTICES'(1);
        depth     <= CNT_W'(1);
        remaining <= count;
      end

      if (state == S_ARC_SCAN && arc_end && found_f && found_t)
        adj[f_slot][t_slot] <= 1'b1;

      if (push_pick) begin
        seen[pick] <= 1'b1;
        depth      <= CNT_W'(1);
      end
      if (emit_visit) begin
        depth     <= depth_m1;
        remaining <= remaining - CNT_W'(1);
      end
      if (push_scan) begin
        seen[jdx] <= 1'b1;
        depth     <= depth + CNT_W'(1);
      end
    end
  end

  // table, stack and payload
  always_ff @(posedge clk) begin
    if (accept) begin
      case (req_type)
        REQ_ADD_VERTEX: begin
          if (count < CNT_W'(MAX_VERTICES)) begin
            values[count[SLOT_W-1:0]] <= vertex_value;
            resp_status               <= ST_OK;
          end else begin
            resp_status <= ST_FULL;
          end
        end
        REQ_ADD_ARC: begin
          req_a   <= vertex_value;
          req_b   <= arc_to_value;
          idx     <= '0;
          found_f <= 1'b0;
          found_t <= 1'b0;
        end
        REQ_TRAVERSE: begin
          resp_status <= ST_EMPTY;
          stack[0]    <= '0;
        end
        default: resp_status <= ST_OK;
      endcase
    end

    if (state == S_ARC_SCAN) begin
      if (!arc_end) begin
        // first match wins for each endpoint
        if (!found_f && (scan_value == req_a)) begin
          found_f <= 1'b1;
          f_slot  <= idx[SLOT_W-1:0];
        end
        if (!found_t && (scan_value == req_b)) begin
          found_t <= 1'b1;
          t_slot  <= idx[SLOT_W-1:0];
        end
        idx <= idx + CNT_W'(1);
      end else begin
        resp_status <= (found_f && found_t) ? ST_OK : ST_NOT_FOUND;
      end
    end

    if (push_pick) stack[0] <= pick;
    if (push_scan) stack[depth[SLOT_W-1:0]] <= jdx;

    if (state == S_SCAN) jdx <= jdx + SLOT_W'(1);

    if (emit_visit) begin
      cur           <= top;
      jdx           <= '0;
      status        <= ST_OK;
      visited_value <= values[top];
      visited_slot  <= top;
      last_of_run   <= (remaining == CNT_W'(1));
    end else if (emit_resp) begin
      status        <= resp_status;
      visited_value <= '0;
      visited_slot  <= '0;
      last_of_run   <= 1'b1;
    end
  end

endmodule
